### src/queue_with_keyed_removal_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH
`define QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define QKR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication, disabled while reset is low
`define QKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

### src/qkr_pkg.sv
package qkr_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;

    localparam int ACTION_W      = 2;
    localparam int VEHICLE_ID_W  = 16;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_QUERY  = 2'd0;
    localparam t_action ACT_PUSH   = 2'd1;
    localparam t_action ACT_POP    = 2'd2;
    localparam t_action ACT_REMOVE = 2'd3;

    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_FULL    = 2'd1;
    localparam t_status STAT_EMPTY   = 2'd2;
    localparam t_status STAT_NOMATCH = 2'd3;

    localparam int IN_TDATA_W = 16;
    localparam int IN_TUSER_W = 8;

    // result beat layout, lowest bit first
    localparam int POPPED_ID_LSB   = 0;
    localparam int POPPED_VLD_BIT  = POPPED_ID_LSB + VEHICLE_ID_W;
    localparam int STATUS_LSB      = POPPED_VLD_BIT + 1;
    localparam int HEAD_ID_LSB     = STATUS_LSB + STATUS_W;
    localparam int HEAD_VLD_BIT    = HEAD_ID_LSB + VEHICLE_ID_W;
    localparam int IS_FIRST_BIT    = HEAD_VLD_BIT + 1;
    localparam int ENTRY_COUNT_LSB = IS_FIRST_BIT + 1;
    localparam int OUT_USED_W      = ENTRY_COUNT_LSB + ENTRY_COUNT_W;
    localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

endpackage

### src/queue_with_keyed_removal.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: vehicle_id[15:0]; tuser: action[1:0], zero above
// m_axis   | out | tdata: popped_id, popped_valid, status, head_id, head_valid,
//          |     |        is_first, entry_count (lowest first), zero above
//
// Entries live in a circular buffer in one memory with a registered read.
// A query or push passes through a head read and a finish state, and a pop
// reads the popped entry first; the result is registered in the finish state,
// which waits while the output register is full and not taken. A remove walks
// the store through the single read port, search then shift toward the head.
// Reset is synchronous and empties the queue; the memory is not cleared.
// One beat is in work at a time; a finished result waits in the output
// register while the next beat is taken.
module queue_with_keyed_removal #(
    parameter int QUEUE_DEPTH = qkr_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = qkr_pkg::DEF_ID_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qkr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // vehicle_id
    input  logic [qkr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // action, zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // popped_id, popped_valid, status, head_id, head_valid, is_first,
    // entry_count, zero pad
    output logic [qkr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import qkr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_POP     = 3'd1;
    localparam logic [2:0] ST_SRCH    = 3'd2;
    localparam logic [2:0] ST_SHIFT   = 3'd3;
    localparam logic [2:0] ST_HEAD_RD = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;

    logic [ID_BITS-1:0]     r_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0]     r_rdata;

    logic [2:0]             r_state, n_state;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_src, n_src;
    logic [CNT_W-1:0]       r_prev, n_prev;
    logic                   r_pend, n_pend;
    logic [ID_BITS-1:0]     r_key, n_key;
    logic [ID_BITS-1:0]     r_popped, n_popped;
    logic                   r_pvalid, n_pvalid;
    t_status                r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                   mem_we;
    logic [PTR_W-1:0]       mem_waddr;
    logic [ID_BITS-1:0]     mem_wdata;
    logic                   mem_re;
    logic [PTR_W-1:0]       mem_raddr;

    logic [ID_BITS-1:0]     key_in;
    t_action                action_in;
    logic                   head_nz;
    logic [ID_BITS-1:0]     head_val;

    // physical slot of the entry at a given distance from the head
    function automatic logic [PTR_W-1:0] f_addr(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    assign key_in    = ID_BITS'(s_axis_tdata);
    assign action_in = s_axis_tuser[ACTION_W-1:0];
    assign head_nz   = (r_count != '0);
    assign head_val  = head_nz ? r_rdata : '0;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_src       = r_src;
        n_prev      = r_prev;
        n_pend      = r_pend;
        n_key       = r_key;
        n_popped    = r_popped;
        n_pvalid    = r_pvalid;
        n_status    = r_status;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = f_addr(r_head, r_count);
        mem_wdata   = key_in;
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key    = key_in;
                    n_status = STAT_OK;
                    n_pvalid = 1'b0;
                    n_popped = '0;
                    n_state  = ST_HEAD_RD;
                    unique case (action_in)
                        ACT_QUERY: begin
                            n_state = ST_HEAD_RD;
                        end
                        ACT_PUSH: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_POP: begin
                            if (!head_nz) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = ST_POP;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!head_nz) begin
                                n_status = STAT_NOMATCH;
                            end else begin
                                n_src   = '0;
                                n_pend  = 1'b0;
                                n_state = ST_SRCH;
                            end
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_popped = r_rdata;
                n_pvalid = 1'b1;
                n_head   = f_addr(r_head, CNT_W'(1));
                n_count  = r_count - CNT_W'(1);
                n_state  = ST_HEAD_RD;
            end
            ST_SRCH: begin
                // read of r_src overlaps the compare of r_prev
                if (r_pend && (r_rdata == r_key)) begin
                    n_src   = r_prev + CNT_W'(1);
                    n_pend  = 1'b0;
                    n_state = ST_SHIFT;
                end else if (r_src < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(r_head, r_src);
                    n_prev    = r_src;
                    n_src     = r_src + CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_status = STAT_NOMATCH;
                    n_pend   = 1'b0;
                    n_state  = ST_HEAD_RD;
                end
            end
            ST_SHIFT: begin
                // write lands one slot behind the read, never the same slot
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_head, r_prev - CNT_W'(1));
                    mem_wdata = r_rdata;
                end
                if (r_src < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(r_head, r_src);
                    n_prev    = r_src;
                    n_src     = r_src + CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                mem_re  = head_nz;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[POPPED_ID_LSB +: VEHICLE_ID_W] = VEHICLE_ID_W'(r_popped);
                    n_out_data[POPPED_VLD_BIT]                = r_pvalid;
                    n_out_data[STATUS_LSB +: STATUS_W]        = r_status;
                    n_out_data[HEAD_ID_LSB +: VEHICLE_ID_W]   = VEHICLE_ID_W'(head_val);
                    n_out_data[HEAD_VLD_BIT]                  = head_nz;
                    n_out_data[IS_FIRST_BIT]                  = head_nz && (r_rdata == r_key);
                    n_out_data[ENTRY_COUNT_LSB +: ENTRY_COUNT_W] = ENTRY_COUNT_W'(r_count);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_prev     <= n_prev;
        r_key      <= n_key;
        r_popped   <= n_popped;
        r_pvalid   <= n_pvalid;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

endmodule

### src/qkr_checker.sv
`include "queue_with_keyed_removal_defines.svh"

module qkr_checker #(
    parameter int QUEUE_DEPTH = qkr_pkg::DEF_QUEUE_DEPTH
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [qkr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import qkr_pkg::*;

    logic                     popped_valid;
    t_status                  status;
    logic [VEHICLE_ID_W-1:0]  head_id;
    logic                     head_valid;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     in_beat;
    logic                     out_wait;
    logic                     empty_fields;

    assign popped_valid = m_axis_tdata[POPPED_VLD_BIT];
    assign status       = m_axis_tdata[STATUS_LSB +: STATUS_W];
    assign head_id      = m_axis_tdata[HEAD_ID_LSB +: VEHICLE_ID_W];
    assign head_valid   = m_axis_tdata[HEAD_VLD_BIT];
    assign entry_count  = m_axis_tdata[ENTRY_COUNT_LSB +: ENTRY_COUNT_W];
    assign in_beat      = s_axis_tvalid && s_axis_tready;
    assign out_wait     = m_axis_tvalid && !m_axis_tready;
    assign empty_fields = (head_id == '0) && (entry_count == '0);

    `QKR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    // one beat in work at a time
    `QKR_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, !s_axis_tready)
    `QKR_ASSERT_IMPL(a_pop_ok, i_clk, i_rst_n, m_axis_tvalid && popped_valid, status == STAT_OK)
    `QKR_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && !head_valid, empty_fields)
    `QKR_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, m_axis_tvalid, int'(entry_count) <= QUEUE_DEPTH)

endmodule

bind queue_with_keyed_removal qkr_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_qkr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
